FILE: rtl/indexed_max_priority_table_defines.svh
// Assertion macros shared by the indexed max priority table modules.
`ifndef INDEXED_MAX_PRIORITY_TABLE_DEFINES_SVH
`define INDEXED_MAX_PRIORITY_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define IMT_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define IMT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/imt_pkg.sv
// Package with the shared types and constants of the indexed max priority table.
`default_nettype none

package imt_pkg;

   localparam int NUM_IDS_DEF       = 256;
   localparam int PRIORITY_BITS_DEF = 16;

   localparam int SLOT_ID_W   = 8;
   localparam int PRIO_FIELD_W = 16;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 8;
   localparam int IDX_MAX_W   = 4;

   typedef enum logic {
      OP_SET  = 1'b0,
      OP_POLL = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIO,
      ST_IDSEL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 load;
      logic                 start;
      logic                 step;
      logic                 id_phase;
      logic                 clear;
      logic [IDX_MAX_W-1:0] id_idx;
   } ctrl_type;

endpackage

`default_nettype wire

FILE: rtl/imt_cell_array.sv
// Row of slot cells with rotating priority shift registers and candidate elimination.
`default_nettype none
`include "indexed_max_priority_table_defines.svh"

module imt_cell_array #(
   parameter int NUM_IDS       = imt_pkg::NUM_IDS_DEF,
   parameter int PRIORITY_BITS = imt_pkg::PRIORITY_BITS_DEF,
   parameter int ID_BITS       = $clog2(imt_pkg::NUM_IDS_DEF)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire imt_pkg::ctrl_type              ctrl,
   input  wire logic [imt_pkg::SLOT_ID_W-1:0]  set_id,
   input  wire logic [PRIORITY_BITS-1:0]       set_prio,
   output logic                                any_hit,
   output logic                                any_active
);

   localparam int IDX_W = (ID_BITS > 1) ? $clog2(ID_BITS) : 1;

   logic [PRIORITY_BITS-1:0] prio_ff [NUM_IDS];
   logic [NUM_IDS-1:0]       active_ff;
   logic [NUM_IDS-1:0]       active_in;
   logic [NUM_IDS-1:0]       cand_ff;
   logic [NUM_IDS-1:0]       cand_in;
   logic [NUM_IDS-1:0]       sel;
   logic [NUM_IDS-1:0]       set_hit;
   logic [IDX_W-1:0]         idx;

   assign idx = ctrl.id_idx[IDX_W-1:0];

   always_comb begin
      logic [ID_BITS-1:0] kid;
      kid = '0;
      for (int k = 0; k < NUM_IDS; k++) begin
         kid        = ID_BITS'(k);
         set_hit[k] = ctrl.load && (32'(set_id) == 32'(k));
         sel[k]     = ctrl.id_phase ? ~kid[idx] : prio_ff[k][PRIORITY_BITS-1];
      end
   end

   assign any_hit    = |(cand_ff & sel);
   assign any_active = |active_ff;

   always_comb begin
      active_in = active_ff | set_hit;
      if (ctrl.clear) begin
         active_in = active_ff & ~cand_ff;
      end
      cand_in = cand_ff;
      if (ctrl.start) begin
         cand_in = active_ff;
      end else if (ctrl.step && any_hit) begin
         cand_in = cand_ff & sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         cand_ff   <= '0;
      end else begin
         active_ff <= active_in;
         cand_ff   <= cand_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_IDS; k++) begin
         if (set_hit[k]) begin
            prio_ff[k] <= set_prio;
         end else if (ctrl.step && !ctrl.id_phase) begin
            prio_ff[k] <= (prio_ff[k] << 1) | (prio_ff[k] >> (PRIORITY_BITS - 1));
         end
      end
   end

   `IMT_ASSERT_SAME(a_single_winner, ctrl.clear, $onehot0(cand_ff), "more than one winner left")
   `IMT_ASSERT_SAME(a_cand_active, ctrl.step, (cand_ff & ~active_ff) == '0, "inactive candidate")
   `IMT_ASSERT_NEXT(a_clear_drops, ctrl.clear, (active_ff & $past(cand_ff)) == '0, "winner still active")

endmodule

`default_nettype wire

FILE: rtl/imt_ctrl.sv
// Sequencer for the bit-serial poll search and the result register.
`default_nettype none
`include "indexed_max_priority_table_defines.svh"

module imt_ctrl #(
   parameter int PRIORITY_BITS = imt_pkg::PRIORITY_BITS_DEF,
   parameter int ID_BITS       = $clog2(imt_pkg::NUM_IDS_DEF)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire imt_pkg::op_type                 req_op,
   output logic                                 req_ready,
   input  wire logic                            any_hit,
   input  wire logic                            any_active,
   output imt_pkg::ctrl_type                    ctrl,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_found,
   output logic [imt_pkg::RSP_DATA_W-1:0]       rsp_winner
);

   localparam int PC_W  = (PRIORITY_BITS > 1) ? $clog2(PRIORITY_BITS) : 1;
   localparam int IDX_W = (ID_BITS > 1) ? $clog2(ID_BITS) : 1;

   imt_pkg::state_type            state_ff, state_in;
   logic [PC_W-1:0]               prio_cnt_ff, prio_cnt_in;
   logic [IDX_W-1:0]              id_cnt_ff, id_cnt_in;
   logic [ID_BITS-1:0]            win_ff, win_in;
   logic                          found_ff, found_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic [imt_pkg::RSP_DATA_W-1:0] rsp_id_ff, rsp_id_in;
   logic                          accept;
   logic                          rsp_load;

   assign req_ready  = (state_ff == imt_pkg::ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign rsp_load   = (state_ff == imt_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_winner = rsp_id_ff;

   always_comb begin
      state_in     = state_ff;
      prio_cnt_in  = prio_cnt_ff;
      id_cnt_in    = id_cnt_ff;
      win_in       = win_ff;
      found_in     = found_ff;
      rsp_found_in = rsp_found_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      ctrl.load     = accept && (req_op == imt_pkg::OP_SET);
      ctrl.start    = accept && (req_op == imt_pkg::OP_POLL);
      ctrl.step     = 1'b0;
      ctrl.id_phase = 1'b0;
      ctrl.clear    = rsp_load;
      ctrl.id_idx   = imt_pkg::IDX_MAX_W'(id_cnt_ff);

      unique case (state_ff)
         imt_pkg::ST_IDLE: begin
            if (ctrl.start) begin
               state_in    = imt_pkg::ST_PRIO;
               prio_cnt_in = PC_W'(PRIORITY_BITS - 1);
               found_in    = any_active;
            end
         end
         imt_pkg::ST_PRIO: begin
            ctrl.step = 1'b1;
            if (prio_cnt_ff == '0) begin
               state_in  = imt_pkg::ST_IDSEL;
               id_cnt_in = IDX_W'(ID_BITS - 1);
            end else begin
               prio_cnt_in = prio_cnt_ff - 1'b1;
            end
         end
         imt_pkg::ST_IDSEL: begin
            ctrl.step     = 1'b1;
            ctrl.id_phase = 1'b1;
            win_in        = (win_ff << 1) | ID_BITS'(!any_hit);
            if (id_cnt_ff == '0) begin
               state_in = imt_pkg::ST_DONE;
            end else begin
               id_cnt_in = id_cnt_ff - 1'b1;
            end
         end
         imt_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in     = imt_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_id_in    = found_ff ? imt_pkg::RSP_DATA_W'(win_ff) : '0;
            end
         end
         default: begin
            state_in = imt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= imt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prio_cnt_ff  <= prio_cnt_in;
      id_cnt_ff    <= id_cnt_in;
      win_ff       <= win_in;
      found_ff     <= found_in;
      rsp_found_ff <= rsp_found_in;
      rsp_id_ff    <= rsp_id_in;
   end

   `IMT_ASSERT_NEXT(a_poll_starts, ctrl.start, state_ff == imt_pkg::ST_PRIO, "poll did not start")
   `IMT_ASSERT_NEXT(a_id_phase_ends, (state_ff == imt_pkg::ST_IDSEL) && (id_cnt_ff == '0), state_ff == imt_pkg::ST_DONE, "id search overran")
   `IMT_ASSERT_NEXT(a_empty_zero, rsp_load && !found_ff, rsp_valid && !rsp_found && (rsp_winner == '0), "empty poll result not zero")

endmodule

`default_nettype wire

FILE: rtl/indexed_max_priority_table.sv
// Top level of the indexed max priority table.
`default_nettype none

// A set request is accepted and returns nothing. A poll request steps through
// the priority phase and the id phase to the done state, where its response
// is registered once no earlier response still waits. The priorities rotate
// through per-slot shift registers one bit per cycle, most significant first,
// dropping candidates without that bit when any candidate has it, then each
// id bit in turn, most significant first, drops the larger ids, leaving the
// lowest id of the highest priority. No request is taken while a poll is in
// progress. Set requests are not held back by a response that waits for
// rsp_tready, but a poll that finishes while the previous response still
// waits keeps req_tready low until that response is taken. No clearing pass
// is needed after reset.
module indexed_max_priority_table #(
   parameter int NUM_IDS       = imt_pkg::NUM_IDS_DEF,
   parameter int PRIORITY_BITS = imt_pkg::PRIORITY_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [imt_pkg::REQ_DATA_W-1:0]    req_tdata,  // slot_id, new_priority
   input  wire logic [0:0]                        req_tuser,  // operation
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [imt_pkg::RSP_DATA_W-1:0]         rsp_tdata,  // winner_id
   output logic [0:0]                             rsp_tuser   // found
);

   localparam int ID_BITS = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;

   imt_pkg::ctrl_type               ctrl;
   imt_pkg::op_type                 req_op;
   logic                            any_hit;
   logic                            any_active;
   logic [imt_pkg::SLOT_ID_W-1:0]   set_id;
   logic [PRIORITY_BITS-1:0]        set_prio;
   logic                            found;

   assign req_op   = imt_pkg::op_type'(req_tuser[0]);
   assign set_id   = req_tdata[imt_pkg::SLOT_ID_W-1:0];
   assign set_prio = PRIORITY_BITS'(req_tdata[imt_pkg::REQ_DATA_W-1:imt_pkg::SLOT_ID_W]);
   assign rsp_tuser = found;

   imt_cell_array #(
      .NUM_IDS       (NUM_IDS),
      .PRIORITY_BITS (PRIORITY_BITS),
      .ID_BITS       (ID_BITS)
   ) u_cells (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .set_id     (set_id),
      .set_prio   (set_prio),
      .any_hit    (any_hit),
      .any_active (any_active)
   );

   imt_ctrl #(
      .PRIORITY_BITS (PRIORITY_BITS),
      .ID_BITS       (ID_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_op     (req_op),
      .req_ready  (req_tready),
      .any_hit    (any_hit),
      .any_active (any_active),
      .ctrl       (ctrl),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_found  (found),
      .rsp_winner (rsp_tdata)
   );

endmodule

`default_nettype wire
